/* rtl/core/osl_pkg.sv */
// ----------------------------------------------------------------------------
// osl_pkg
// Shared types and constants for the object file section loader.
// ----------------------------------------------------------------------------
`default_nettype none

package osl_pkg;

    // Width of the internal write address; it wraps at this width
    localparam int ADDR_WIDTH = 16;

    localparam logic [15:0] HDR_CODE     = 16'hCADE;
    localparam logic [15:0] HDR_DATA     = 16'hDADA;
    localparam logic [15:0] HDR_SYMBOL   = 16'hC3B7;
    localparam logic [15:0] HDR_FILENAME = 16'h717E;
    localparam logic [15:0] HDR_LINE     = 16'h715E;

    localparam logic [15:0] LINE_WORDS = 16'd3;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_ADDRESS,
        PH_COUNT,
        PH_PAYLOAD,
        PH_SKIP_BYTES,
        PH_SKIP_WORDS
    } t_phase;

    typedef enum logic [2:0] {
        SK_CODE,
        SK_DATA,
        SK_SYMBOL,
        SK_FILENAME,
        SK_LINE
    } t_section;

    typedef enum logic {
        KIND_WRITE = 1'b0,
        KIND_ERROR = 1'b1
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] address;
        logic [15:0] data;
    } t_result;

endpackage

`default_nettype wire

/* rtl/core/object_file_section_loader_core.sv */
// ----------------------------------------------------------------------------
// object_file_section_loader_core
// Byte-serial object file loader: turns code and data sections into memory
// word writes, skips symbol, filename and line sections, flags bad headers.
//
//   channel  dir  handshake                payload
//   -------  ---  -----------------------  ---------------------------
//   in       in   i_in_valid / o_in_stall  i_byte_req
//   out      out  o_out_valid / i_out_stall o_kind, o_address, o_data
//
// One byte per cycle sustained while the output is not stalled; the outcome of a
// byte is loaded into the result register after the byte has passed the input
// register and the parser step, which waits while the result register is stalled.
// Reset clears the parser to expect a header word and empties both stages.
// An output stall holds the result register and backs up into o_in_stall
// only once the input register holds a byte the parser cannot retire.
// ----------------------------------------------------------------------------
`default_nettype none

module object_file_section_loader_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [7:0]  i_byte_req,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic             o_kind,
    output logic [15:0]      o_address,
    output logic [15:0]      o_data
);

    logic             r_in_valid;
    logic [7:0]       r_in_byte;
    logic             step;
    logic             out_free;
    logic             res_valid;
    osl_pkg::t_result res;
    osl_pkg::t_result out_res;

    // retire the held byte when the result register can take its outcome
    assign step       = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in_byte <= i_byte_req;
        end
    end

    osl_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_byte      (r_in_byte),
        .o_res       (res),
        .o_res_valid (res_valid)
    );

    osl_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (step && res_valid),
        .i_res       (res),
        .i_out_stall (i_out_stall),
        .o_full      (o_out_valid),
        .o_free      (out_free),
        .o_res       (out_res)
    );

    assign o_kind    = out_res.kind;
    assign o_address = out_res.address;
    assign o_data    = out_res.data;

endmodule

`default_nettype wire

/* rtl/core/osl_parser.sv */
// ----------------------------------------------------------------------------
// osl_parser
// Section parser: pairs bytes into words, walks the section layout and
// produces memory writes or the invalid header error.
// ----------------------------------------------------------------------------
`default_nettype none

module osl_parser (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_step,
    input  wire logic [7:0]      i_byte,
    output osl_pkg::t_result     o_res,
    output logic                 o_res_valid
);

    osl_pkg::t_phase                     r_phase, n_phase;
    osl_pkg::t_section                   r_section, n_section;
    logic                                r_pending, n_pending;
    logic [7:0]                          r_upper, n_upper;
    logic [osl_pkg::ADDR_WIDTH-1:0]      r_addr, n_addr;
    logic [15:0]                         r_count, n_count;
    logic                                r_failed, n_failed;

    logic [15:0] word;
    logic [31:0] addr_wide;
    logic        is_write;

    assign word      = {r_upper, i_byte};
    assign addr_wide = 32'(r_addr);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= osl_pkg::PH_HEADER;
            r_section <= osl_pkg::SK_CODE;
            r_pending <= 1'b0;
            r_upper   <= 8'd0;
            r_addr    <= '0;
            r_count   <= 16'd0;
            r_failed  <= 1'b0;
        end else if (i_step) begin
            r_phase   <= n_phase;
            r_section <= n_section;
            r_pending <= n_pending;
            r_upper   <= n_upper;
            r_addr    <= n_addr;
            r_count   <= n_count;
            r_failed  <= n_failed;
        end
    end

    always_comb begin
        n_phase     = r_phase;
        n_section   = r_section;
        n_pending   = r_pending;
        n_upper     = r_upper;
        n_addr      = r_addr;
        n_count     = r_count;
        n_failed    = r_failed;
        o_res_valid = 1'b0;
        o_res.kind    = osl_pkg::KIND_WRITE;
        o_res.address = addr_wide[15:0];
        o_res.data    = word;

        if (!r_failed) begin
            if (r_phase == osl_pkg::PH_SKIP_BYTES) begin
                // byte-counted skip ignores word pairing
                n_count = r_count - 16'd1;
                if (r_count == 16'd1) begin
                    n_phase = osl_pkg::PH_HEADER;
                end
            end else if (!r_pending) begin
                n_upper   = i_byte;
                n_pending = 1'b1;
            end else begin
                n_pending = 1'b0;
                unique case (r_phase)
                    osl_pkg::PH_HEADER: begin
                        if (word == osl_pkg::HDR_CODE) begin
                            n_section = osl_pkg::SK_CODE;
                            n_phase   = osl_pkg::PH_ADDRESS;
                        end else if (word == osl_pkg::HDR_DATA) begin
                            n_section = osl_pkg::SK_DATA;
                            n_phase   = osl_pkg::PH_ADDRESS;
                        end else if (word == osl_pkg::HDR_SYMBOL) begin
                            n_section = osl_pkg::SK_SYMBOL;
                            n_phase   = osl_pkg::PH_ADDRESS;
                        end else if (word == osl_pkg::HDR_FILENAME) begin
                            n_section = osl_pkg::SK_FILENAME;
                            n_phase   = osl_pkg::PH_COUNT;
                        end else if (word == osl_pkg::HDR_LINE) begin
                            n_section = osl_pkg::SK_LINE;
                            n_count   = osl_pkg::LINE_WORDS;
                            n_phase   = osl_pkg::PH_SKIP_WORDS;
                        end else begin
                            // unknown header: report once, then drop everything
                            n_failed      = 1'b1;
                            o_res_valid   = 1'b1;
                            o_res.kind    = osl_pkg::KIND_ERROR;
                            o_res.address = 16'd0;
                        end
                    end
                    osl_pkg::PH_ADDRESS: begin
                        n_addr  = osl_pkg::ADDR_WIDTH'(word);
                        n_phase = osl_pkg::PH_COUNT;
                    end
                    osl_pkg::PH_COUNT: begin
                        n_count = word;
                        if (word == 16'd0) begin
                            n_phase = osl_pkg::PH_HEADER;
                        end else if (r_section == osl_pkg::SK_CODE ||
                                     r_section == osl_pkg::SK_DATA) begin
                            n_phase = osl_pkg::PH_PAYLOAD;
                        end else begin
                            n_phase = osl_pkg::PH_SKIP_BYTES;
                        end
                    end
                    osl_pkg::PH_PAYLOAD: begin
                        o_res_valid = 1'b1;
                        n_addr      = r_addr + osl_pkg::ADDR_WIDTH'(1);
                        n_count     = r_count - 16'd1;
                        if (r_count == 16'd1) begin
                            n_phase = osl_pkg::PH_HEADER;
                        end
                    end
                    osl_pkg::PH_SKIP_WORDS: begin
                        n_count = r_count - 16'd1;
                        if (r_count == 16'd1) begin
                            n_phase = osl_pkg::PH_HEADER;
                        end
                    end
                    default: begin
                        n_phase = osl_pkg::PH_HEADER;
                    end
                endcase
            end
        end
    end

    assign is_write = o_res_valid && (o_res.kind == osl_pkg::KIND_WRITE);

    a_no_result_after_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_failed |-> !o_res_valid)
        else $error("result produced after header error");

    a_write_only_in_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        is_write |-> (r_phase == osl_pkg::PH_PAYLOAD && r_pending))
        else $error("memory write outside payload");

    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == osl_pkg::PH_PAYLOAD || r_phase == osl_pkg::PH_SKIP_BYTES ||
         r_phase == osl_pkg::PH_SKIP_WORDS) |-> (r_count != 16'd0))
        else $error("counted phase with zero count");

    a_skip_bytes_unpaired: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == osl_pkg::PH_SKIP_BYTES) |-> !r_pending)
        else $error("byte skip entered with a held upper byte");

    a_addr_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && is_write) |=> (r_addr == $past(r_addr) + osl_pkg::ADDR_WIDTH'(1)))
        else $error("write address did not advance");

endmodule

`default_nettype wire

/* rtl/core/osl_out_reg.sv */
// ----------------------------------------------------------------------------
// osl_out_reg
// Result register: holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module osl_out_reg (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_load,
    input  osl_pkg::t_result      i_res,
    input  wire logic             i_out_stall,
    output logic                  o_full,
    output logic                  o_free,
    output osl_pkg::t_result      o_res
);

    logic             r_valid;
    osl_pkg::t_result r_res;

    // free when empty or being drained this cycle
    assign o_free = !r_valid || !i_out_stall;
    assign o_full = r_valid;
    assign o_res  = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

endmodule

`default_nettype wire

/* bench/object_file_section_loader_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// object_file_section_loader_core_tb
// Streams object file bytes into the loader and checks every memory write and
// the bad header error against a byte-level parser model kept in the bench.
// A short directed table comes first. Random well-formed sections follow,
// with header-like words hidden in their content. The run closes on a bad
// header and trailing bytes that the block must ignore. Both channels idle
// at random.
// ----------------------------------------------------------------------------
module object_file_section_loader_core_tb;

    localparam int HALF_PERIOD  = 5;
    localparam int RESET_CYCLES = 11;
    localparam int RANDOM_ITEMS = 350;
    localparam int QUIET_ITEMS  = 60;
    localparam int IDLE_LIMIT   = 1000;
    localparam int DRAIN_CYCLES = 20;

    typedef struct packed {
        logic [7:0]       b;
        bit               typed;
        osl_pkg::t_result res;
    } t_row;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic [7:0]  i_byte_req  = 8'h00;
    logic        i_out_stall = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic        o_kind;
    logic [15:0] o_address;
    logic [15:0] o_data;

    // parser copy kept by the bench
    osl_pkg::t_phase                ld_phase     = osl_pkg::PH_HEADER;
    osl_pkg::t_section              ld_section   = osl_pkg::SK_CODE;
    bit                             ld_pending   = 1'b0;
    logic [7:0]                     ld_upper     = 8'h00;
    logic [osl_pkg::ADDR_WIDTH-1:0] ld_addr      = '0;
    logic [15:0]                    ld_remaining = 16'h0000;
    bit                             ld_failed    = 1'b0;

    osl_pkg::t_result due_results [$];
    t_row             opening_rows [$];
    t_row             closing_rows [$];

    bit quiet      = 1'b0;
    int n_bytes    = 0;
    int n_checked  = 0;
    int n_fail     = 0;
    int n_sections [0:4] = '{0, 0, 0, 0, 0};
    int out_hold   = 0;

    object_file_section_loader_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_byte_req  (i_byte_req),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_kind      (o_kind),
        .o_address   (o_address),
        .o_data      (o_data)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    function automatic t_row plain(input logic [7:0] b);
        t_row row;
        row = '0;
        row.b = b;
        return row;
    endfunction

    function automatic t_row write_row(input logic [7:0] b, input logic [15:0] addr,
                                       input logic [15:0] data);
        t_row row;
        row = '0;
        row.b = b;
        row.typed = 1'b1;
        row.res.kind = osl_pkg::KIND_WRITE;
        row.res.address = addr;
        row.res.data = data;
        return row;
    endfunction

    function automatic t_row error_row(input logic [7:0] b, input logic [15:0] data);
        t_row row;
        row = '0;
        row.b = b;
        row.typed = 1'b1;
        row.res.kind = osl_pkg::KIND_ERROR;
        row.res.address = 16'h0000;
        row.res.data = data;
        return row;
    endfunction

    // Advance the parser by one byte; fired marks a result in r.
    function automatic void parse_byte(input logic [7:0] b, output bit fired,
                                       output osl_pkg::t_result r);
        logic [15:0] word;
        fired = 1'b0;
        r = '0;
        if (ld_failed)
            return;
        if (ld_phase == osl_pkg::PH_SKIP_BYTES) begin
            ld_remaining = ld_remaining - 16'd1;
            if (ld_remaining == 16'd0)
                ld_phase = osl_pkg::PH_HEADER;
            return;
        end
        if (!ld_pending) begin
            ld_upper = b;
            ld_pending = 1'b1;
            return;
        end
        ld_pending = 1'b0;
        word = {ld_upper, b};
        case (ld_phase)
            osl_pkg::PH_HEADER: begin
                case (word)
                    osl_pkg::HDR_CODE: begin
                        ld_section = osl_pkg::SK_CODE;
                        ld_phase = osl_pkg::PH_ADDRESS;
                    end
                    osl_pkg::HDR_DATA: begin
                        ld_section = osl_pkg::SK_DATA;
                        ld_phase = osl_pkg::PH_ADDRESS;
                    end
                    osl_pkg::HDR_SYMBOL: begin
                        ld_section = osl_pkg::SK_SYMBOL;
                        ld_phase = osl_pkg::PH_ADDRESS;
                    end
                    osl_pkg::HDR_FILENAME: begin
                        ld_section = osl_pkg::SK_FILENAME;
                        ld_phase = osl_pkg::PH_COUNT;
                    end
                    osl_pkg::HDR_LINE: begin
                        ld_section = osl_pkg::SK_LINE;
                        ld_remaining = osl_pkg::LINE_WORDS;
                        ld_phase = osl_pkg::PH_SKIP_WORDS;
                    end
                    default: begin
                        ld_failed = 1'b1;
                        fired = 1'b1;
                        r.kind = osl_pkg::KIND_ERROR;
                        r.address = 16'h0000;
                        r.data = word;
                    end
                endcase
            end
            osl_pkg::PH_ADDRESS: begin
                ld_addr = osl_pkg::ADDR_WIDTH'(word);
                ld_phase = osl_pkg::PH_COUNT;
            end
            osl_pkg::PH_COUNT: begin
                ld_remaining = word;
                if (word == 16'd0)
                    ld_phase = osl_pkg::PH_HEADER;
                else if (ld_section == osl_pkg::SK_CODE || ld_section == osl_pkg::SK_DATA)
                    ld_phase = osl_pkg::PH_PAYLOAD;
                else
                    ld_phase = osl_pkg::PH_SKIP_BYTES;
            end
            osl_pkg::PH_PAYLOAD: begin
                fired = 1'b1;
                r.kind = osl_pkg::KIND_WRITE;
                r.address = 16'(ld_addr);
                r.data = word;
                ld_addr = ld_addr + osl_pkg::ADDR_WIDTH'(1);
                ld_remaining = ld_remaining - 16'd1;
                if (ld_remaining == 16'd0)
                    ld_phase = osl_pkg::PH_HEADER;
            end
            osl_pkg::PH_SKIP_WORDS: begin
                ld_remaining = ld_remaining - 16'd1;
                if (ld_remaining == 16'd0)
                    ld_phase = osl_pkg::PH_HEADER;
            end
            default: ld_phase = osl_pkg::PH_HEADER;
        endcase
    endfunction

    // Called at a falling edge; returns at the falling edge after the transaction.
    task automatic send_row(input t_row row);
        int               gap;
        bit               fired;
        osl_pkg::t_result got;
        gap = (!quiet && $urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_byte_req <= row.b;
        @(posedge i_clk);
        while (o_in_stall !== 1'b0)
            @(posedge i_clk);
        parse_byte(row.b, fired, got);
        if (row.typed)
            due_results.push_back(row.res);
        else if (fired)
            due_results.push_back(got);
        n_bytes++;
        @(negedge i_clk);
    endtask

    task automatic send_word(input logic [15:0] w);
        send_row(plain(w[15:8]));
        send_row(plain(w[7:0]));
    endtask

    // One well-formed section with random content.
    task automatic send_section();
        int          sel;
        int          count;
        logic [15:0] w;
        sel = $urandom_range(0, 19);
        if (sel < 14) begin
            send_word(sel < 8 ? osl_pkg::HDR_CODE : osl_pkg::HDR_DATA);
            // bias the start toward the top so the address wraps now and then
            if ($urandom_range(0, 3) == 0)
                w = 16'hFFFF - 16'($urandom_range(0, 4));
            else
                w = 16'($urandom);
            send_word(w);
            case ($urandom_range(0, 9))
                0:       count = 0;
                1:       count = $urandom_range(10, 30);
                default: count = $urandom_range(1, 6);
            endcase
            send_word(16'(count));
            repeat (count) begin
                // hide header words in the payload; the parser must not resync
                case ($urandom_range(0, 11))
                    0:       w = osl_pkg::HDR_CODE;
                    1:       w = osl_pkg::HDR_LINE;
                    2:       w = osl_pkg::HDR_SYMBOL;
                    default: w = 16'($urandom);
                endcase
                send_word(w);
            end
            if (sel < 8)
                n_sections[osl_pkg::SK_CODE]++;
            else
                n_sections[osl_pkg::SK_DATA]++;
        end else if (sel < 18) begin
            send_word(sel < 16 ? osl_pkg::HDR_SYMBOL : osl_pkg::HDR_FILENAME);
            if (sel < 16)
                send_word(16'($urandom));
            count = $urandom_range(0, 11);
            send_word(16'(count));
            repeat (count) send_row(plain(8'($urandom)));
            if (sel < 16)
                n_sections[osl_pkg::SK_SYMBOL]++;
            else
                n_sections[osl_pkg::SK_FILENAME]++;
        end else begin
            send_word(osl_pkg::HDR_LINE);
            repeat (osl_pkg::LINE_WORDS) send_word(16'($urandom));
            n_sections[osl_pkg::SK_LINE]++;
        end
    endtask

    // Output stall in random bursts.
    always @(negedge i_clk) begin
        if (!i_rst_n || quiet) begin
            i_out_stall <= 1'b0;
            out_hold <= 0;
        end else if (out_hold > 0) begin
            i_out_stall <= 1'b1;
            out_hold <= out_hold - 1;
        end else if ($urandom_range(0, 5) == 0) begin
            i_out_stall <= 1'b1;
            out_hold <= $urandom_range(0, 2);
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin : check_results
        osl_pkg::t_result want;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            if (due_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual kind %0d %s %h %s %h",
                         $time, o_kind, "address", o_address, "data", o_data);
                n_fail++;
            end else begin
                want = due_results.pop_front();
                n_checked++;
                if (o_kind !== want.kind) begin
                    $display("%0t: kind mismatch, expected %0d actual %0d",
                             $time, want.kind, o_kind);
                    n_fail++;
                end
                if (o_address !== want.address) begin
                    $display("%0t: address mismatch, expected %h actual %h",
                             $time, want.address, o_address);
                    n_fail++;
                end
                if (o_data !== want.data) begin
                    $display("%0t: data mismatch, expected %h actual %h",
                             $time, want.data, o_data);
                    n_fail++;
                end
            end
        end
    end

    initial begin : watchdog
        int idle;
        idle = 0;
        wait (i_rst_n === 1'b1);
        while (idle < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_stall === 1'b0) ||
                (o_out_valid === 1'b1 && !i_out_stall))
                idle = 0;
            else
                idle++;
        end
        $display("%0t: no transaction for %0d cycles, %0d results still due",
                 $time, IDLE_LIMIT, due_results.size());
        $display("object_file_section_loader_core verification failed");
        $finish;
    end

    initial begin : stimulus
        int n_opening;
        int half_mark;
        int quiet_mark;
        int stop_mark;
        bit paused;
        paused = 1'b0;
        opening_rows = '{
            // code at the top of memory, data extremes, address wraps
            plain(8'hCA), plain(8'hDE), plain(8'hFF), plain(8'hFF),
            plain(8'h00), plain(8'h02),
            plain(8'h00), write_row(8'h00, 16'hFFFF, 16'h0000),
            plain(8'hFF), write_row(8'hFF, 16'h0000, 16'hFFFF),
            // data section with zero count
            plain(8'hDA), plain(8'hDA), plain(8'h00), plain(8'h00),
            plain(8'h00), plain(8'h00),
            // symbol section of one byte: next header lands on an odd byte
            plain(8'hC3), plain(8'hB7), plain(8'h00), plain(8'h00),
            plain(8'h00), plain(8'h01), plain(8'hA5),
            // filename with zero count
            plain(8'h71), plain(8'h7E), plain(8'h00), plain(8'h00),
            // line section
            plain(8'h71), plain(8'h5E), plain(8'h12), plain(8'h34),
            plain(8'h56), plain(8'h78), plain(8'h9A), plain(8'hBC)
        };
        // bad header, then a full code section that must be ignored
        closing_rows = '{
            plain(8'hFF), error_row(8'hFF, 16'hFFFF),
            plain(8'hCA), plain(8'hDE), plain(8'h00), plain(8'h00),
            plain(8'h00), plain(8'h01), plain(8'h12), plain(8'h34),
            plain(8'h7F)
        };
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (opening_rows[k]) send_row(opening_rows[k]);
        n_opening = n_bytes;

        stop_mark = n_bytes + RANDOM_ITEMS;
        half_mark = n_bytes + RANDOM_ITEMS / 2;
        quiet_mark = stop_mark - QUIET_ITEMS;
        while (n_bytes < stop_mark) begin
            send_section();
            if (n_bytes >= quiet_mark)
                quiet = 1'b1;
            if (!paused && n_bytes >= half_mark) begin
                // hold the stream until every write due has come out
                i_in_valid <= 1'b0;
                while (due_results.size() != 0)
                    @(posedge i_clk);
                @(negedge i_clk);
                paused = 1'b1;
            end
        end
        quiet = 1'b1;

        foreach (closing_rows[k]) send_row(closing_rows[k]);
        i_in_valid <= 1'b0;
        while (due_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d bytes: %0d directed, then sections of code %0d, data %0d,",
                 n_bytes, n_opening, n_sections[osl_pkg::SK_CODE],
                 n_sections[osl_pkg::SK_DATA]);
        $display("  symbol %0d, filename %0d, line %0d; closed on a bad header",
                 n_sections[osl_pkg::SK_SYMBOL], n_sections[osl_pkg::SK_FILENAME],
                 n_sections[osl_pkg::SK_LINE]);
        $display("Checked %0d results with %0d mismatches", n_checked, n_fail);
        if (n_fail == 0)
            $display("object_file_section_loader_core verification clean");
        else
            $display("object_file_section_loader_core verification failed");
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/osl_pkg.sv
rtl/core/osl_parser.sv
rtl/core/osl_out_reg.sv
rtl/core/object_file_section_loader_core.sv
bench/object_file_section_loader_core_tb.sv
